@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the line stepper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge out of reset.
`define LSTEP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Flag a condition that must never be seen out of reset.
`define LSTEP_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define LSTEP_ASSERT(lbl, clk, rst_n, prop, msg)
`define LSTEP_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

@@ hw/rtl/lstep_pkg.sv @@
// Package: command codes, widths and defaults for the line stepper.
package lstep_pkg;

  localparam int CoordBits         = 24;
  localparam int CmdBits           = 2;
  localparam int POSITION_BITS_DEF = 24;

  typedef enum logic [CmdBits-1:0] {
    CMD_TICK = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_SET  = 2'd2
  } cmd_t;

endpackage

@@ hw/rtl/lstep_ifs.sv @@
// Channel interfaces: command word in, stepper result word out.
interface lstep_cmd_if;
  logic                                  valid;
  logic                                  ready;
  logic [lstep_pkg::CmdBits-1:0]         command;
  logic signed [lstep_pkg::CoordBits-1:0] target_x;
  logic signed [lstep_pkg::CoordBits-1:0] target_y;

  modport source (output valid, command, target_x, target_y, input ready);
  modport sink   (input valid, command, target_x, target_y, output ready);
endinterface

interface lstep_res_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  x_step_lvl;
  logic                                  x_dir_lvl;
  logic                                  y_step_lvl;
  logic                                  y_dir_lvl;
  logic                                  x_moved;
  logic                                  y_moved;
  logic                                  busy_res;
  logic signed [lstep_pkg::CoordBits-1:0] position_x;
  logic signed [lstep_pkg::CoordBits-1:0] position_y;

  modport source (output valid, x_step_lvl, x_dir_lvl, y_step_lvl, y_dir_lvl,
                  x_moved, y_moved, busy_res, position_x, position_y,
                  input ready);
  modport sink   (input valid, x_step_lvl, x_dir_lvl, y_step_lvl, y_dir_lvl,
                  x_moved, y_moved, busy_res, position_x, position_y,
                  output ready);
endinterface

@@ hw/rtl/two_axis_line_stepper_unit.sv @@
// Two-axis Bresenham step generator: command register, step logic, result register.
//
// Usage:
//   in_cmd carries one command word: tick (advance the line by one step
//   interval), load (set the goal and start a move) or set (overwrite the
//   current position and set the move up again toward the stored goal).
//   Every command word yields exactly one result word on out_res: the four
//   step/direction pin levels, which axes stepped, whether the move was busy
//   at tick start, and the current position.
//   out_res.valid rises once the result of an accepted word is loaded: the
//   word waits in the command register and its result is loaded into the
//   result register once that register is free. Throughput is one word per
//   cycle while out_res does not stall; the bound is the combinational add,
//   compare and subtract per axis on the registered error counters.
//   When out_res stalls the result register holds, the command register
//   fills behind it, and in_cmd.ready drops only once both are full.
//   Synchronous reset (rst_n low) empties both registers, puts position,
//   goal, deltas and error counters at zero, x reverse and y forward flags
//   at one, and all pins low. No clearing pass is needed.
`include "assert_macros.svh"

module two_axis_line_stepper_unit #(
  parameter int POSITION_BITS = lstep_pkg::POSITION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  lstep_cmd_if.sink          in_cmd,
  lstep_res_if.source        out_res
);

  localparam int P = POSITION_BITS;
  localparam int D = POSITION_BITS + 1;  // signed difference
  localparam int E = POSITION_BITS + 2;  // error counter
  localparam int C = lstep_pkg::CoordBits;

  // command register
  logic                          cmd_vld_r;
  logic [lstep_pkg::CmdBits-1:0] cmd_r;
  logic signed [C-1:0]           tx_r, ty_r;

  // move state
  logic signed [P-1:0] cur_x_r, cur_y_r, goal_x_r, goal_y_r;
  logic [P-1:0]        dx_r, dy_r, maj_r;
  logic signed [E-1:0] err_x_r, err_y_r;
  logic                x_rev_r, y_fwd_r;
  logic                x_stp_r, x_dir_r, y_stp_r, y_dir_r;

  // result register
  logic                res_vld_r;
  logic                res_xm_r, res_ym_r, res_busy_r;
  logic signed [C-1:0] res_px_r, res_py_r;

  // next values
  logic signed [P-1:0] cur_x_nxt, cur_y_nxt, goal_x_nxt, goal_y_nxt;
  logic [P-1:0]        dx_nxt, dy_nxt, maj_nxt;
  logic signed [E-1:0] err_x_nxt, err_y_nxt;
  logic                x_rev_nxt, y_fwd_nxt;
  logic                x_stp_nxt, x_dir_nxt, y_stp_nxt, y_dir_nxt;
  logic                xm_nxt, ym_nxt, busy_nxt;

  // setup and tick datapath
  logic signed [P-1:0] tgt_x, tgt_y, su_goal_x, su_goal_y, su_cur_x, su_cur_y;
  logic signed [D-1:0] diff_x, diff_y;
  logic [P-1:0]        su_dx, su_dy, su_maj;
  logic signed [E-1:0] su_err;
  logic signed [E-1:0] sum_x, sum_y;
  logic                x_pend, y_pend, x_fire, y_fire;
  logic                is_tick, is_load, is_set;
  logic                adv;

  // hand off: the result register frees up or is empty
  assign adv          = cmd_vld_r && (!res_vld_r || out_res.ready);
  assign in_cmd.ready = !cmd_vld_r || adv;

  // decode the command word
  always_comb begin
    is_tick = 1'b0;
    is_load = 1'b0;
    is_set  = 1'b0;
    unique case (lstep_pkg::cmd_t'(cmd_r))
      lstep_pkg::CMD_TICK: is_tick = 1'b1;
      lstep_pkg::CMD_LOAD: is_load = 1'b1;
      lstep_pkg::CMD_SET:  is_set  = 1'b1;
      default: ;
    endcase
  end

  // set up a move from the new goal or new position
  always_comb begin
    tgt_x     = P'(tx_r);
    tgt_y     = P'(ty_r);
    su_goal_x = is_load ? tgt_x : goal_x_r;
    su_goal_y = is_load ? tgt_y : goal_y_r;
    su_cur_x  = is_set  ? tgt_x : cur_x_r;
    su_cur_y  = is_set  ? tgt_y : cur_y_r;
    diff_x    = D'(su_goal_x) - D'(su_cur_x);
    diff_y    = D'(su_goal_y) - D'(su_cur_y);
    su_dx     = diff_x[D-1] ? P'(-diff_x) : P'(diff_x);
    su_dy     = diff_y[D-1] ? P'(-diff_y) : P'(diff_y);
    su_maj    = (su_dy > su_dx) ? su_dy : su_dx;
    su_err    = E'(0) - E'(su_maj >> 1);
  end

  // advance each axis that is not yet at its goal
  always_comb begin
    x_pend = cur_x_r != goal_x_r;
    y_pend = cur_y_r != goal_y_r;
    sum_x  = err_x_r + E'(dx_r);
    sum_y  = err_y_r + E'(dy_r);
    x_fire = is_tick && x_pend && !sum_x[E-1] && (sum_x != '0);
    y_fire = is_tick && y_pend && !sum_y[E-1] && (sum_y != '0);
  end

  // select next state and result
  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    goal_x_nxt = goal_x_r;
    goal_y_nxt = goal_y_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    maj_nxt    = maj_r;
    err_x_nxt  = err_x_r;
    err_y_nxt  = err_y_r;
    x_rev_nxt  = x_rev_r;
    y_fwd_nxt  = y_fwd_r;
    x_stp_nxt  = x_stp_r;
    x_dir_nxt  = x_dir_r;
    y_stp_nxt  = y_stp_r;
    y_dir_nxt  = y_dir_r;
    xm_nxt     = 1'b0;
    ym_nxt     = 1'b0;
    busy_nxt   = 1'b0;
    if (is_load || is_set) begin
      cur_x_nxt  = su_cur_x;
      cur_y_nxt  = su_cur_y;
      goal_x_nxt = su_goal_x;
      goal_y_nxt = su_goal_y;
      dx_nxt     = su_dx;
      dy_nxt     = su_dy;
      maj_nxt    = su_maj;
      err_x_nxt  = su_err;
      err_y_nxt  = su_err;
      x_rev_nxt  = diff_x[D-1];
      y_fwd_nxt  = !diff_y[D-1];
    end else if (is_tick) begin
      busy_nxt = x_pend || y_pend;
      if (x_pend) begin
        err_x_nxt = sum_x;
      end
      if (y_pend) begin
        err_y_nxt = sum_y;
      end
      if (x_fire) begin
        err_x_nxt = sum_x - E'(maj_r);
        cur_x_nxt = x_rev_r ? cur_x_r - P'(1) : cur_x_r + P'(1);
        x_stp_nxt = !x_stp_r;
        x_dir_nxt = x_rev_r;
        xm_nxt    = 1'b1;
      end
      if (y_fire) begin
        err_y_nxt = sum_y - E'(maj_r);
        cur_y_nxt = y_fwd_r ? cur_y_r + P'(1) : cur_y_r - P'(1);
        y_stp_nxt = !y_stp_r;
        y_dir_nxt = y_fwd_r;
        ym_nxt    = 1'b1;
      end
    end
  end

  // capture the incoming word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
    end else if (in_cmd.ready) begin
      cmd_vld_r <= in_cmd.valid;
    end
    if (in_cmd.valid && in_cmd.ready) begin
      cmd_r <= in_cmd.command;
      tx_r  <= in_cmd.target_x;
      ty_r  <= in_cmd.target_y;
    end
  end

  // update move state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      goal_x_r <= '0;
      goal_y_r <= '0;
      dx_r     <= '0;
      dy_r     <= '0;
      maj_r    <= '0;
      err_x_r  <= '0;
      err_y_r  <= '0;
      x_rev_r  <= 1'b1;
      y_fwd_r  <= 1'b1;
      x_stp_r  <= 1'b0;
      x_dir_r  <= 1'b0;
      y_stp_r  <= 1'b0;
      y_dir_r  <= 1'b0;
    end else if (adv) begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      goal_x_r <= goal_x_nxt;
      goal_y_r <= goal_y_nxt;
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      maj_r    <= maj_nxt;
      err_x_r  <= err_x_nxt;
      err_y_r  <= err_y_nxt;
      x_rev_r  <= x_rev_nxt;
      y_fwd_r  <= y_fwd_nxt;
      x_stp_r  <= x_stp_nxt;
      x_dir_r  <= x_dir_nxt;
      y_stp_r  <= y_stp_nxt;
      y_dir_r  <= y_dir_nxt;
    end
  end

  // hold the result word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (adv) begin
      res_vld_r <= 1'b1;
    end else if (out_res.ready) begin
      res_vld_r <= 1'b0;
    end
    if (adv) begin
      res_xm_r   <= xm_nxt;
      res_ym_r   <= ym_nxt;
      res_busy_r <= busy_nxt;
      res_px_r   <= C'(cur_x_nxt);
      res_py_r   <= C'(cur_y_nxt);
    end
  end

  // drive the result channel; pins come straight from the pin state
  assign out_res.valid      = res_vld_r;
  assign out_res.x_step_lvl = x_stp_r;
  assign out_res.x_dir_lvl  = x_dir_r;
  assign out_res.y_step_lvl = y_stp_r;
  assign out_res.y_dir_lvl  = y_dir_r;
  assign out_res.x_moved    = res_xm_r;
  assign out_res.y_moved    = res_ym_r;
  assign out_res.busy_res   = res_busy_r;
  assign out_res.position_x = res_px_r;
  assign out_res.position_y = res_py_r;

  // checks
  `LSTEP_NEVER(a_err_x_pos, clk, rst_n, !err_x_r[E-1] && (err_x_r != '0), "x error counter went positive")
  `LSTEP_NEVER(a_err_y_pos, clk, rst_n, !err_y_r[E-1] && (err_y_r != '0), "y error counter went positive")
  `LSTEP_NEVER(a_move_busy, clk, rst_n, res_vld_r && (res_xm_r || res_ym_r) && !res_busy_r, "step reported without busy")
  `LSTEP_ASSERT(a_no_clobber, clk, rst_n, (res_vld_r && !out_res.ready) |-> !adv, "pending result overwritten")
  `LSTEP_ASSERT(a_x_steps, clk, rst_n, (adv && x_fire) |=> (cur_x_r != $past(cur_x_r)), "x step without position change")

endmodule

@@ tb/sv/lstep_result_checker.sv @@
// Result checker for the two-axis line stepper: predicts each result word and compares.
module lstep_result_checker (
  input  logic  clk,
  input  logic  rst_n,
  lstep_cmd_if  cmd_ch,
  lstep_res_if  res_ch,
  output int    mismatches,
  output int    pending,
  output int    words_checked,
  output int    axis_steps
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CoordBits   = lstep_pkg::CoordBits;
  localparam int CmdBits     = lstep_pkg::CmdBits;
  localparam int ReportLimit = 10;

  typedef struct packed {
    logic                 x_step_lvl;
    logic                 x_dir_lvl;
    logic                 y_step_lvl;
    logic                 y_dir_lvl;
    logic                 x_moved;
    logic                 y_moved;
    logic                 busy_res;
    logic [CoordBits-1:0] position_x;
    logic [CoordBits-1:0] position_y;
  } step_word_t;

  // Predicted machine state
  logic signed [CoordBits-1:0] pos_x, pos_y, goal_x, goal_y;
  logic [CoordBits-1:0]        dist_x, dist_y, dist_major;
  logic signed [CoordBits+1:0] err_x, err_y;
  logic                        x_rev, y_fwd;
  logic [3:0]                  pins;

  step_word_t expected_words[$];
  int bad_words, seen_words, steps_total;

  function automatic logic [CoordBits-1:0] span_between(
      input logic signed [CoordBits-1:0] a, input logic signed [CoordBits-1:0] b);
    logic signed [CoordBits:0] d;
    d = {a[CoordBits-1], a} - {b[CoordBits-1], b};
    if (d < 0) d = -d;
    return d[CoordBits-1:0];
  endfunction

  // Set the move up from the current position toward the stored goal
  function automatic void plan_move();
    dist_x     = span_between(goal_x, pos_x);
    dist_y     = span_between(goal_y, pos_y);
    x_rev      = (goal_x < pos_x);
    y_fwd      = (goal_y >= pos_y);
    dist_major = (dist_y > dist_x) ? dist_y : dist_x;
    err_x      = -$signed({2'b00, dist_major >> 1});
    err_y      = err_x;
  endfunction

  // Apply one command word to the predicted state and build its result word
  function automatic step_word_t advance_stepper(input logic [CmdBits-1:0] op,
      input logic [CoordBits-1:0] tx, input logic [CoordBits-1:0] ty);
    step_word_t w;
    logic       x_open, y_open;
    w = '0;
    case (op)
      lstep_pkg::CMD_LOAD: begin
        goal_x = tx;
        goal_y = ty;
        plan_move();
      end
      lstep_pkg::CMD_SET: begin
        pos_x = tx;
        pos_y = ty;
        plan_move();
      end
      lstep_pkg::CMD_TICK: begin
        x_open = (pos_x != goal_x);
        y_open = (pos_y != goal_y);
        w.busy_res = x_open || y_open;
        if (x_open) begin
          err_x = err_x + $signed({2'b00, dist_x});
          if (err_x > 0) begin
            pins[0]   = ~pins[0];
            pins[1]   = x_rev;
            err_x     = err_x - $signed({2'b00, dist_major});
            pos_x     = x_rev ? pos_x - 1'b1 : pos_x + 1'b1;
            w.x_moved = 1'b1;
          end
        end
        if (y_open) begin
          err_y = err_y + $signed({2'b00, dist_y});
          if (err_y > 0) begin
            pins[2]   = ~pins[2];
            pins[3]   = y_fwd;
            err_y     = err_y - $signed({2'b00, dist_major});
            pos_y     = y_fwd ? pos_y + 1'b1 : pos_y - 1'b1;
            w.y_moved = 1'b1;
          end
        end
      end
      default: ;  // unused code leaves the state alone
    endcase
    w.x_step_lvl = pins[0];
    w.x_dir_lvl  = pins[1];
    w.y_step_lvl = pins[2];
    w.y_dir_lvl  = pins[3];
    w.position_x = pos_x;
    w.position_y = pos_y;
    return w;
  endfunction

  function automatic string describe(input step_word_t w);
    return $sformatf("pins xs=%b xd=%b ys=%b yd=%b moved x=%b y=%b busy=%b pos=(%0d,%0d)",
                     w.x_step_lvl, w.x_dir_lvl, w.y_step_lvl, w.y_dir_lvl,
                     w.x_moved, w.y_moved, w.busy_res,
                     $signed(w.position_x), $signed(w.position_y));
  endfunction

  always @(posedge clk) begin
    step_word_t want, got;
    if (!rst_n) begin
      // Hold the prediction at its reset state
      pos_x = '0; pos_y = '0; goal_x = '0; goal_y = '0;
      dist_x = '0; dist_y = '0; dist_major = '0;
      err_x = '0; err_y = '0;
      x_rev = 1'b1; y_fwd = 1'b1;
      pins = '0;
      expected_words.delete();
      bad_words = 0; seen_words = 0; steps_total = 0;
    end else begin
      // Predict every accepted command word
      if (cmd_ch.valid && cmd_ch.ready) begin
        want = advance_stepper(cmd_ch.command, cmd_ch.target_x, cmd_ch.target_y);
        steps_total += want.x_moved + want.y_moved;
        expected_words.push_back(want);
      end
      // Compare every accepted result word with the oldest prediction
      if (res_ch.valid && res_ch.ready) begin
        got.x_step_lvl = res_ch.x_step_lvl;
        got.x_dir_lvl  = res_ch.x_dir_lvl;
        got.y_step_lvl = res_ch.y_step_lvl;
        got.y_dir_lvl  = res_ch.y_dir_lvl;
        got.x_moved    = res_ch.x_moved;
        got.y_moved    = res_ch.y_moved;
        got.busy_res   = res_ch.busy_res;
        got.position_x = res_ch.position_x;
        got.position_y = res_ch.position_y;
        seen_words++;
        if (expected_words.size() == 0) begin
          bad_words++;
          if (bad_words <= ReportLimit)
            $display("%0t: result word with nothing expected: %s", $realtime, describe(got));
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            bad_words++;
            if (bad_words <= ReportLimit) begin
              $display("%0t: result word %0d differs", $realtime, seen_words);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end
    end
    mismatches    <= bad_words;
    pending       <= expected_words.size();
    words_checked <= seen_words;
    axis_steps    <= steps_total;
  end

endmodule

@@ tb/sv/two_axis_line_stepper_unit_test.sv @@
// Testbench top for the two-axis line stepper: clock, reset, command stimulus and verdict.
module two_axis_line_stepper_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CoordBits = lstep_pkg::CoordBits;
  localparam int CmdBits   = lstep_pkg::CmdBits;
  localparam logic [CmdBits-1:0] CmdUnused = 2'd3;
  localparam int MaxPos      = 8388607;
  localparam int MinPos      = -8388608;
  localparam int RandomWords = 1850;
  localparam int DrainCycles = 8;
  // Idle limit, well above a fully stalled receiver pattern plus a sender gap
  localparam int IdleLimit   = 2000;

  logic clk;
  logic rst_n;
  int   burst_left;
  int   words_sent;
  int   idle_cycles;
  int   stall_phase;
  int   stall_mode;
  logic [7:0] stall_mask;

  int mismatches, pending, words_checked, axis_steps;

  lstep_cmd_if cmd_ch ();
  lstep_res_if res_ch ();

  two_axis_line_stepper_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_cmd  (cmd_ch),
    .out_res (res_ch)
  );

  lstep_result_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_ch        (cmd_ch),
    .res_ch        (res_ch),
    .mismatches    (mismatches),
    .pending       (pending),
    .words_checked (words_checked),
    .axis_steps    (axis_steps)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the result side on a pattern that changes each time the stall phase wraps
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      stall_phase  <= 0;
      stall_mode   <= 0;
      stall_mask   <= '1;
    end else begin
      if (stall_phase == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_mask <= 8'($urandom);
      end
      stall_phase <= (stall_phase == 47) ? 0 : stall_phase + 1;
      case (stall_mode)
        0:       res_ch.ready <= 1'b1;
        1:       res_ch.ready <= 1'($urandom_range(0, 1));
        2:       res_ch.ready <= stall_mask[stall_phase % 8];
        default: res_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("[two_axis_line_stepper_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one command word in bursts with random gaps; return once accepted
  task automatic send_word(input logic [CmdBits-1:0] op, input int tx, input int ty);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_ch.valid    <= 1'b1;
    cmd_ch.command  <= op;
    cmd_ch.target_x <= tx[CoordBits-1:0];
    cmd_ch.target_y <= ty[CoordBits-1:0];
    do @(posedge clk); while (!cmd_ch.ready);
    words_sent++;
  endtask

  // Ticks ignore the coordinates, so fill them with noise
  task automatic tick_times(input int count);
    repeat (count) send_word(lstep_pkg::CMD_TICK, $urandom, $urandom);
  endtask

  function automatic int clamp_pos(input int v);
    if (v > MaxPos) return MaxPos;
    if (v < MinPos) return MinPos;
    return v;
  endfunction

  function automatic int nudge(input int base, input int reach);
    return clamp_pos(base + int'($urandom_range(0, 2 * reach)) - reach);
  endfunction

  // Pick a start point, often at the edges of the coordinate range
  function automatic int pick_origin();
    case ($urandom_range(0, 7))
      0:       return MaxPos;
      1:       return MinPos;
      default: return int'({{8{1'b0}}, 24'($urandom)} << 8) >>> 8;
    endcase
  endfunction

  function automatic int abs_i(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Well-formed move: set origin, load a nearby goal, tick to the end,
  // sometimes cut short or restarted from a new position mid-move
  task automatic run_line();
    int ox, oy, gx, gy, sx, sy, reach, n;
    reach = ($urandom_range(0, 3) == 0) ? 48 : 12;
    ox = pick_origin();
    oy = pick_origin();
    gx = nudge(ox, reach);
    gy = ($urandom_range(0, 5) == 0) ? oy : nudge(oy, reach);
    if ($urandom_range(0, 7) == 0) gx = ox;
    send_word(lstep_pkg::CMD_SET, ox, oy);
    send_word(lstep_pkg::CMD_LOAD, gx, gy);
    n = (abs_i(gx - ox) > abs_i(gy - oy)) ? abs_i(gx - ox) : abs_i(gy - oy);
    if ($urandom_range(0, 5) == 0) begin
      tick_times($urandom_range(0, n));
      sx = nudge(ox, reach);
      sy = nudge(oy, reach);
      send_word(lstep_pkg::CMD_SET, sx, sy);
      n = (abs_i(gx - sx) > abs_i(gy - sy)) ? abs_i(gx - sx) : abs_i(gy - sy);
    end
    tick_times(n + $urandom_range(0, 2));
  endtask

  initial begin
    int pick;
    rst_n           = 1'b0;
    cmd_ch.valid    = 1'b0;
    cmd_ch.command  = lstep_pkg::CMD_TICK;
    cmd_ch.target_x = '0;
    cmd_ch.target_y = '0;
    burst_left      = 0;
    words_sent      = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle tick, unused code, extremes, set mid-move, huge deltas
    send_word(lstep_pkg::CMD_TICK, 0, 0);
    send_word(CmdUnused, MaxPos, MinPos);
    send_word(lstep_pkg::CMD_SET, MaxPos, MinPos);
    tick_times(2);
    send_word(lstep_pkg::CMD_SET, MaxPos, MinPos);
    send_word(lstep_pkg::CMD_LOAD, MaxPos - 5, MinPos + 2);
    tick_times(6);
    send_word(lstep_pkg::CMD_SET, MinPos, MaxPos);
    send_word(lstep_pkg::CMD_LOAD, MinPos + 2, MaxPos - 4);
    tick_times(5);
    send_word(lstep_pkg::CMD_LOAD, MaxPos, MinPos);
    tick_times(1);
    send_word(lstep_pkg::CMD_SET, MaxPos - 1, MinPos);
    tick_times(2);

    // Random: mostly complete moves, some noise and abandoned moves
    while (words_sent < RandomWords) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        run_line();
      end else if (pick == 7) begin
        send_word(($urandom_range(0, 1) == 0) ? CmdUnused : lstep_pkg::CMD_TICK,
                  $urandom, $urandom);
      end else if (pick == 8) begin
        send_word(lstep_pkg::CMD_LOAD, $urandom, $urandom);
        tick_times($urandom_range(1, 3));
      end else begin
        send_word(lstep_pkg::CMD_SET, $urandom, $urandom);
        tick_times($urandom_range(1, 3));
      end
    end
    cmd_ch.valid <= 1'b0;

    // Drain the result side, then let the pipeline sit quiet before the verdict
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Checked %0d result words covering %0d predicted axis steps,", words_checked,
             axis_steps);
    $display("with edge-of-range moves, unused codes and mid-move position resets.");
    if (mismatches == 0 && pending == 0) begin
      $display("[two_axis_line_stepper_unit] OK");
    end else begin
      $display("[two_axis_line_stepper_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/lstep_pkg.sv
hw/rtl/lstep_ifs.sv
hw/rtl/two_axis_line_stepper_unit.sv
tb/sv/lstep_result_checker.sv
tb/sv/two_axis_line_stepper_unit_test.sv
